### rtl/ccu_pkg.sv
// Shared widths and payload types for the colex combination unrank core.
// No dependencies; used by the core and the port checker.
package ccu_pkg;

   localparam int SITE_W        = 7;
   localparam int RANK_W        = 63;
   localparam int PAT_W         = 64;
   localparam int BINOM_W       = 64;
   localparam int MAX_SITES_DEF = 64;

   typedef logic [SITE_W-1:0]  site_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [PAT_W-1:0]   pat_type;
   typedef logic [BINOM_W-1:0] binom_type;

endpackage

### rtl/ccu_ram.sv
// Generic single-clock RAM: one write port and one read port, read data registered.
// No dependencies; holds the binomial table of the core.
module ccu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4225
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/combination_colex_unrank_core.sv
// Colex combination unrank core: greedy descent over a binomial table in RAM.
// Depends on ccu_pkg and ccu_ram.
//
//   channel | direction | payload                                   | handshake
//   req     | in        | site_count, ones_count, rank_index        | req_valid / req_ready
//   rsp     | out       | pattern, bad_request                      | rsp_valid / rsp_ready
//
// After reset a fill pass writes the binomial table, reading in ST_FILL_RD and writing
// in ST_FILL_WR for each entry; req_ready stays low meanwhile.
// A word then passes through accept, lookup, range check, one table read per position
// walked from n-1 down, and result load. Rejected requests skip the walk: a bad shape
// ends at lookup, a rank out of range at the range check. The table RAM read port sets the pace.
// A finished result waits in the output register; the next word is taken meanwhile.
module combination_colex_unrank_core #(
   parameter int MAX_SITES = ccu_pkg::MAX_SITES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ccu_pkg::site_type  req_site_count,
   input  ccu_pkg::site_type  req_ones_count,
   input  ccu_pkg::rank_type  req_rank_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ccu_pkg::pat_type   rsp_pattern,
   output logic               rsp_bad_request
);

   localparam int TAB_DIM = MAX_SITES + 1;
   localparam int DEPTH   = TAB_DIM * TAB_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(TAB_DIM);

   localparam logic [2:0] ST_FILL_RD = 3'd0;
   localparam logic [2:0] ST_FILL_WR = 3'd1;
   localparam logic [2:0] ST_IDLE    = 3'd2;
   localparam logic [2:0] ST_LOOKUP  = 3'd3;
   localparam logic [2:0] ST_CHECK   = 3'd4;
   localparam logic [2:0] ST_WALK    = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;

   function automatic logic [ADDR_W-1:0] tab_addr(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
      return ADDR_W'(a) * ADDR_W'(TAB_DIM) + ADDR_W'(b);
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    fa_ff, fa_in;
   logic [CNT_W-1:0]    fb_ff, fb_in;
   ccu_pkg::binom_type  col_ff, col_in;
   ccu_pkg::site_type   n_ff, n_in;
   ccu_pkg::site_type   k_ff, k_in;
   ccu_pkg::rank_type   rem_ff, rem_in;
   logic [CNT_W-1:0]    p_ff, p_in;
   logic [CNT_W-1:0]    j_ff, j_in;
   ccu_pkg::pat_type    pat_ff, pat_in;
   logic                bad_ff, bad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ccu_pkg::pat_type    rsp_pattern_ff, rsp_pattern_in;
   logic                rsp_bad_ff, rsp_bad_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   ccu_pkg::binom_type  wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   ccu_pkg::binom_type  rd_data;

   logic                req_fire;
   logic                shape_bad;
   logic                hit;
   ccu_pkg::binom_type  rem_ext;
   ccu_pkg::binom_type  rem_diff;
   ccu_pkg::binom_type  fill_val;

   ccu_ram #(
      .WIDTH (ccu_pkg::BINOM_W),
      .DEPTH (DEPTH)
   ) u_binom_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign shape_bad = (n_ff > ccu_pkg::site_type'(MAX_SITES)) || (k_ff > n_ff);
   assign rem_ext   = {1'b0, rem_ff};
   assign hit       = (rd_data <= rem_ext);
   assign rem_diff  = rem_ext - rd_data;

   always_comb begin
      if (fb_ff == '0) begin
         fill_val = ccu_pkg::binom_type'(1);
      end else if (fa_ff == '0) begin
         fill_val = '0;
      end else begin
         fill_val = col_ff + rd_data;
      end
   end

   always_comb begin
      state_in       = state_ff;
      fa_in          = fa_ff;
      fb_in          = fb_ff;
      col_in         = col_ff;
      n_in           = n_ff;
      k_in           = k_ff;
      rem_in         = rem_ff;
      p_in           = p_ff;
      j_in           = j_ff;
      pat_in         = pat_ff;
      bad_in         = bad_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_pattern_in = rsp_pattern_ff;
      rsp_bad_in     = rsp_bad_ff;
      wr_en          = 1'b0;
      wr_addr        = tab_addr(fa_ff, fb_ff);
      wr_data        = fill_val;
      rd_addr        = '0;

      unique case (state_ff)
         ST_FILL_RD: begin
            if ((fa_ff != '0) && (fb_ff != '0)) begin
               rd_addr = tab_addr(fa_ff - 1'b1, fb_ff - 1'b1);
            end
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            wr_en  = 1'b1;
            col_in = fill_val;
            if (fa_ff == CNT_W'(MAX_SITES)) begin
               fa_in = '0;
               if (fb_ff == CNT_W'(MAX_SITES)) begin
                  state_in = ST_IDLE;
               end else begin
                  fb_in    = fb_ff + 1'b1;
                  state_in = ST_FILL_RD;
               end
            end else begin
               fa_in    = fa_ff + 1'b1;
               state_in = ST_FILL_RD;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               n_in     = req_site_count;
               k_in     = req_ones_count;
               rem_in   = req_rank_index;
               pat_in   = '0;
               bad_in   = 1'b0;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (shape_bad) begin
               bad_in   = 1'b1;
               state_in = ST_EMIT;
            end else begin
               rd_addr  = tab_addr(n_ff[CNT_W-1:0], k_ff[CNT_W-1:0]);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rem_ext >= rd_data) begin
               bad_in   = 1'b1;
               state_in = ST_EMIT;
            end else if (k_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               p_in     = n_ff[CNT_W-1:0] - 1'b1;
               j_in     = k_ff[CNT_W-1:0];
               rd_addr  = tab_addr(n_ff[CNT_W-1:0] - 1'b1, k_ff[CNT_W-1:0]);
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            p_in = p_ff - 1'b1;
            if (hit) begin
               pat_in  = pat_ff | (ccu_pkg::pat_type'(1) << p_ff);
               rem_in  = rem_diff[ccu_pkg::RANK_W-1:0];
               j_in    = j_ff - 1'b1;
               rd_addr = tab_addr(p_ff - 1'b1, j_ff - 1'b1);
               if (j_ff == CNT_W'(1)) begin
                  state_in = ST_EMIT;
               end
            end else begin
               rd_addr = tab_addr(p_ff - 1'b1, j_ff);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pattern_in = pat_ff;
               rsp_bad_in     = bad_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_FILL_RD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL_RD;
         fa_ff        <= '0;
         fb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fa_ff        <= fa_in;
         fb_ff        <= fb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff         <= col_in;
      n_ff           <= n_in;
      k_ff           <= k_in;
      rem_ff         <= rem_in;
      p_ff           <= p_in;
      j_ff           <= j_in;
      pat_ff         <= pat_in;
      bad_ff         <= bad_in;
      rsp_pattern_ff <= rsp_pattern_in;
      rsp_bad_ff     <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pattern     = rsp_pattern_ff;
   assign rsp_bad_request = rsp_bad_ff;

endmodule

### rtl/ccu_checker.sv
// Port-level assertions for the colex combination unrank core, bound to its top level.
// Depends on ccu_pkg and combination_colex_unrank_core.
module ccu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ccu_pkg::pat_type  rsp_pattern,
   input logic              rsp_bad_request
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("core not quiet after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         rsp_valid && $stable(rsp_pattern) && $stable(rsp_bad_request))
      else $error("stalled result word changed");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_request) |-> (rsp_pattern == '0))
      else $error("rejected request returned a nonzero pattern");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word taken while one is in flight");

endmodule

bind combination_colex_unrank_core ccu_checker u_ccu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pattern     (rsp_pattern),
   .rsp_bad_request (rsp_bad_request)
);
